[rtl/core/sevseg_pkg.sv]
// Shared types, constants and glyph table for the seven-segment display driver.
package sevseg_pkg;

    localparam int DIGITS     = 4;
    localparam int IDX_W      = $clog2(DIGITS);
    localparam int SEG_W      = 8;
    localparam int VAL_W      = 16;
    localparam int FD_W       = 2;
    localparam int KIND_W     = 2;
    localparam int PERIOD_W   = 16;
    localparam int MAG_W      = 14;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2;

    localparam logic signed [VAL_W-1:0] VAL_POS_LIMIT = 16'sd10000;
    localparam logic signed [VAL_W-1:0] VAL_NEG_LIMIT = -16'sd1000;

    // Reciprocal constants: q = (m * R) >> S is exact for m < 10000.
    localparam int RECIP10_W    = 13;
    localparam int RECIP100_W   = 13;
    localparam int RECIP1000_W  = 14;
    localparam logic [RECIP10_W-1:0]   RECIP10   = 13'd6554;
    localparam logic [RECIP100_W-1:0]  RECIP100  = 13'd5243;
    localparam logic [RECIP1000_W-1:0] RECIP1000 = 14'd8389;
    localparam int SHIFT10   = 16;
    localparam int SHIFT100  = 19;
    localparam int SHIFT1000 = 23;

    localparam int Q1_W = 10;   // m / 10
    localparam int Q2_W = 7;    // m / 100
    localparam int Q3_W = 4;    // m / 1000

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_INT   = 2'd1,
        KIND_FIXED = 2'd2
    } t_kind;

    typedef logic [SEG_W-1:0] t_seg;

    function automatic t_seg glyph(input logic [3:0] d);
        t_seg g;
        unique case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

[rtl/core/four_digit_seven_segment_driver.sv]
// Four-digit multiplexed seven-segment driver: decimal conversion, patterns and scan.
//
// Takes one item per clock unless the input stalls. An item passes an input register,
// a stage that forms the decimal quotients by constant reciprocal multiplies, and a
// stage that updates the digit patterns, the refresh divider and the scan index, which
// writes a scan result into the output register. Input stalls only when a scan result
// is ready while the output register still holds an untaken result and the two buffer
// stages are full. refresh_period must be written only while the block is idle; the
// block does not enforce it. A value of zero gives one scan step every 65536 ticks.
module four_digit_seven_segment_driver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sevseg_pkg::PERIOD_W-1:0]   i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sevseg_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // value[15:0], frac_cnt[17:16]
    input  logic [sevseg_pkg::KIND_W-1:0]     s_axis_tuser,   // kind[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sevseg_pkg::OUT_DATA_W-1:0] m_axis_tdata    // segments[7:0], digit_select[11:8]
);
    import sevseg_pkg::*;

    // input register
    logic                    r_in_valid;
    t_kind                   r_in_kind;
    logic signed [VAL_W-1:0] r_in_value;
    logic [FD_W-1:0]         r_in_fd;

    // quotient stage
    logic              r_a_valid;
    t_kind             r_a_kind;
    logic [FD_W-1:0]   r_a_fd;
    logic              r_a_neg;
    logic              r_a_ok;
    logic [MAG_W-1:0]  r_a_mag;
    logic [Q1_W-1:0]   r_a_q1;
    logic [Q2_W-1:0]   r_a_q2;
    logic [Q3_W-1:0]   r_a_q3;

    // display state
    t_seg                r_pat [DIGITS];
    t_seg                n_pat [DIGITS];
    logic [IDX_W-1:0]    r_scan, n_scan;
    logic [PERIOD_W-1:0] r_div, n_div;
    logic [PERIOD_W-1:0] r_period;

    // output register
    logic                r_out_valid;
    t_seg                r_out_seg;
    logic [DIGITS-1:0]   r_out_sel;

    logic a_move, b_fire, emit;
    t_seg              w_seg;
    logic [DIGITS-1:0] w_sel;

    // ---------------- quotient stage logic ----------------
    logic [VAL_W-1:0]                 w_abs;
    logic [MAG_W-1:0]                 w_mag;
    logic [MAG_W+RECIP10_W-1:0]       w_p1;
    logic [MAG_W+RECIP100_W-1:0]      w_p2;
    logic [MAG_W+RECIP1000_W-1:0]     w_p3;
    logic                             w_ok_pos, w_ok_neg, w_ok;

    assign w_abs = r_in_value[VAL_W-1] ? VAL_W'(-r_in_value) : VAL_W'(r_in_value);
    assign w_mag = w_abs[MAG_W-1:0];
    assign w_p1  = (MAG_W+RECIP10_W)'(w_mag) * (MAG_W+RECIP10_W)'(RECIP10);
    assign w_p2  = (MAG_W+RECIP100_W)'(w_mag) * (MAG_W+RECIP100_W)'(RECIP100);
    assign w_p3  = (MAG_W+RECIP1000_W)'(w_mag) * (MAG_W+RECIP1000_W)'(RECIP1000);

    assign w_ok_pos = !r_in_value[VAL_W-1] && (r_in_value < VAL_POS_LIMIT);
    assign w_ok_neg = r_in_value[VAL_W-1] && (r_in_value > VAL_NEG_LIMIT);

    always_comb begin
        w_ok = 1'b0;
        unique case (r_in_kind)
            KIND_INT:   w_ok = w_ok_pos || w_ok_neg;
            KIND_FIXED: w_ok = (w_ok_pos && r_in_fd != 2'd0)
                            || (w_ok_neg && (r_in_fd == 2'd1 || r_in_fd == 2'd2));
            default:    w_ok = 1'b0;
        endcase
    end

    // ---------------- update stage logic ----------------
    logic [3:0]      d0, d1, d2, d3;
    logic [MAG_W-1:0] w_r0;
    logic [Q1_W-1:0]  w_r1;
    logic [Q2_W-1:0]  w_r2;
    logic [PERIOD_W-1:0] w_div_inc;
    logic [IDX_W-1:0]    w_idx;
    logic                blank3, blank2, blank1;

    assign w_r0 = r_a_mag - MAG_W'(r_a_q1) * MAG_W'(10);
    assign w_r1 = r_a_q1 - Q1_W'(r_a_q2) * Q1_W'(10);
    assign w_r2 = r_a_q2 - Q2_W'(r_a_q3) * Q2_W'(10);
    assign d0 = w_r0[3:0];
    assign d1 = w_r1[3:0];
    assign d2 = w_r2[3:0];
    assign d3 = r_a_q3;

    assign blank3 = (r_pat[3] == SEG_BLANK);
    assign blank2 = (r_pat[2] == SEG_BLANK);
    assign blank1 = (r_pat[1] == SEG_BLANK);
    assign w_div_inc = r_div + PERIOD_W'(1);

    // scan index wraps early while the upper digits are blank
    always_comb begin
        priority if (blank3 && blank2 && blank1) begin
            w_idx = '0;
        end else if (blank3 && blank2) begin
            w_idx = {1'b0, r_scan[0]};
        end else if (blank3) begin
            w_idx = (r_scan == IDX_W'(3)) ? '0 : r_scan;
        end else begin
            w_idx = r_scan;
        end
    end

    always_comb begin
        n_pat  = r_pat;
        n_scan = r_scan;
        n_div  = r_div;
        emit   = 1'b0;
        w_seg  = r_pat[w_idx];
        w_sel  = DIGITS'(1) << w_idx;
        unique case (r_a_kind)
            KIND_TICK: begin
                n_div = w_div_inc;
                if (w_div_inc == r_period) begin
                    emit   = 1'b1;
                    n_div  = '0;
                    n_scan = w_idx + IDX_W'(1);
                end
            end
            KIND_INT: begin
                if (r_a_ok) begin
                    n_pat[0] = glyph(d0);
                    if (!r_a_neg) begin
                        n_pat[1] = (r_a_q1 != '0) ? glyph(d1) : SEG_BLANK;
                        n_pat[2] = (r_a_q2 != '0) ? glyph(d2) : SEG_BLANK;
                        n_pat[3] = (r_a_q3 != '0) ? glyph(d3) : SEG_BLANK;
                    end else if (r_a_q1 == '0) begin
                        n_pat[1] = SEG_MINUS;
                        n_pat[2] = SEG_BLANK;
                        n_pat[3] = SEG_BLANK;
                    end else if (r_a_q2 == '0) begin
                        n_pat[1] = glyph(d1);
                        n_pat[2] = SEG_MINUS;
                        n_pat[3] = SEG_BLANK;
                    end else begin
                        n_pat[1] = glyph(d1);
                        n_pat[2] = glyph(d2);
                        n_pat[3] = SEG_MINUS;
                    end
                end
            end
            KIND_FIXED: begin
                if (r_a_ok) begin
                    n_pat[0] = glyph(d0);
                    n_pat[1] = glyph(d1);   // zero pad up to the units digit
                    if (!r_a_neg) begin
                        n_pat[2] = (r_a_q2 != '0 || r_a_fd >= 2'd2) ? glyph(d2) : SEG_BLANK;
                        n_pat[3] = (r_a_q3 != '0 || r_a_fd == 2'd3) ? glyph(d3) : SEG_BLANK;
                    end else if (r_a_q2 != '0) begin
                        n_pat[2] = glyph(d2);
                        n_pat[3] = SEG_MINUS;
                    end else begin
                        n_pat[2] = (r_a_fd == 2'd1) ? SEG_MINUS : glyph(4'd0);
                        n_pat[3] = (r_a_fd == 2'd2) ? SEG_MINUS : SEG_BLANK;
                    end
                    n_pat[r_a_fd] = n_pat[r_a_fd] | SEG_POINT;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- flow control ----------------
    assign b_fire        = r_a_valid && !(emit && r_out_valid && !m_axis_tready);
    assign a_move        = !r_a_valid || b_fire;
    assign s_axis_tready = !r_in_valid || a_move;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-SEG_W-DIGITS){1'b0}}, r_out_sel, r_out_seg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_div       <= '0;
            r_period    <= PERIOD_RESET;
            for (int i = 0; i < DIGITS; i++) begin
                r_pat[i] <= SEG_BLANK;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (a_move) begin
                r_a_valid <= r_in_valid;
            end
            if (b_fire) begin
                r_pat  <= n_pat;
                r_scan <= n_scan;
                r_div  <= n_div;
            end
            if (b_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind  <= t_kind'(s_axis_tuser);
            r_in_value <= s_axis_tdata[VAL_W-1:0];
            r_in_fd    <= s_axis_tdata[VAL_W+FD_W-1:VAL_W];
        end
        if (a_move && r_in_valid) begin
            r_a_kind <= r_in_kind;
            r_a_fd   <= r_in_fd;
            r_a_neg  <= r_in_value[VAL_W-1];
            r_a_ok   <= w_ok;
            r_a_mag  <= w_mag;
            r_a_q1   <= w_p1[SHIFT10+Q1_W-1:SHIFT10];
            r_a_q2   <= w_p2[SHIFT100+Q2_W-1:SHIFT100];
            r_a_q3   <= w_p3[SHIFT1000+Q3_W-1:SHIFT1000];
        end
        if (b_fire && emit) begin
            r_out_seg <= w_seg;
            r_out_sel <= w_sel;
        end
    end

    // ---------------- assertions ----------------
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_out_sel))
        else $error("digit select not one-hot");

    a_div_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && emit) |=> (r_div == '0))
        else $error("divider not cleared after scan step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_seg)
                                             && $stable(r_out_sel)))
        else $error("pending result overwritten");

    a_scan_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && emit && blank3) |-> !w_sel[3])
        else $error("blank top digit scanned");

endmodule

[sim/tb.sv]
// Testbench for the four-digit seven-segment driver: directed table, random items, scoreboard.
`timescale 1ns / 100ps

module tb;
    import sevseg_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT    = 50_000;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        t_seg       seg;
        logic [3:0] sel;
    } t_scan_out;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  val;
        logic [FD_W-1:0]   fd;
        logic              typed;
        t_seg              seg;
        logic [3:0]        sel;
    } t_dir_row;

    localparam t_seg DIGIT_SEG [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                         8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    // Directed items; typed expectations only on tick rows, after reset or integer shows.
    localparam int NDIR = 33;
    t_dir_row dir_rows [NDIR] = '{
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h00, 4'h1},  // blank display after reset
        '{KIND_INT,   16'd9999,   2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h6F, 4'h2},
        '{KIND_INT,   16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h3F, 4'h1},  // upper blank, scan forced to 0
        '{KIND_INT,   -16'sd999,  2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h6F, 4'h2},
        '{KIND_INT,   -16'sd1,    2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h06, 4'h1},  // two-digit wrap
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h40, 4'h2},  // minus sign
        '{KIND_INT,   16'd10000,  2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_INT,   -16'sd1000, 2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_INT,   16'h8000,   2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b1, 8'h06, 4'h1},  // out-of-range shows kept -1
        '{KIND_FIXED, 16'd5,      2'd3, 1'b0, 8'h00, 4'h0},
        '{KIND_FIXED, 16'd5,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_FIXED, -16'sd5,    2'd1, 1'b0, 8'h00, 4'h0},
        '{KIND_FIXED, -16'sd5,    2'd3, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_FIXED, -16'sd123,  2'd2, 1'b0, 8'h00, 4'h0},
        '{KIND_SPARE, 16'hFFFF,   2'd3, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0},
        '{KIND_TICK,  16'd0,      2'd0, 1'b0, 8'h00, 4'h0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0]   i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value[15:0], frac_cnt[17:16]
    logic [KIND_W-1:0]     s_axis_tuser = '0;   // kind[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // segments[7:0], digit_select[11:8]

    // Display model state
    t_seg          disp_pat [DIGITS] = '{default: SEG_BLANK};
    logic [1:0]    scan_pos = '0;
    logic [15:0]   tick_count = '0;
    logic [15:0]   refresh_period_q = PERIOD_RESET;

    t_scan_out scan_exp_q [$];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        tx_idle_on = 1'b1;
    bit        rx_idle_on = 1'b1;
    bit        rx_hold_req = 1'b0;

    four_digit_seven_segment_driver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[four_digit_seven_segment_driver] ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch @%0d: %s got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    function automatic void show_integer(input int v);
        int m;
        if (v >= 0 && v < 10000) begin
            m = v;
            disp_pat[0] = DIGIT_SEG[m % 10];
            m /= 10;
            disp_pat[1] = (m != 0) ? DIGIT_SEG[m % 10] : SEG_BLANK;
            m /= 10;
            disp_pat[2] = (m != 0) ? DIGIT_SEG[m % 10] : SEG_BLANK;
            m /= 10;
            disp_pat[3] = (m != 0) ? DIGIT_SEG[m % 10] : SEG_BLANK;
        end else if (v < 0 && v > -1000) begin
            m = -v;
            disp_pat[0] = DIGIT_SEG[m % 10];
            m /= 10;
            if (m == 0) begin
                disp_pat[1] = SEG_MINUS;
                disp_pat[2] = SEG_BLANK;
                disp_pat[3] = SEG_BLANK;
            end else begin
                disp_pat[1] = DIGIT_SEG[m % 10];
                m /= 10;
                if (m == 0) begin
                    disp_pat[2] = SEG_MINUS;
                    disp_pat[3] = SEG_BLANK;
                end else begin
                    disp_pat[2] = DIGIT_SEG[m % 10];
                    disp_pat[3] = SEG_MINUS;
                end
            end
        end
    endfunction

    function automatic void show_fixed(input int v, input int fd);
        int m;
        if (v >= 0 && v < 10000 && fd >= 1 && fd <= 3) begin
            m = v;
            disp_pat[0] = DIGIT_SEG[m % 10];
            m /= 10;
            disp_pat[1] = (m != 0) ? DIGIT_SEG[m % 10] : DIGIT_SEG[0];
            m /= 10;
            disp_pat[2] = (m != 0) ? DIGIT_SEG[m % 10] : (fd >= 2 ? DIGIT_SEG[0] : SEG_BLANK);
            m /= 10;
            disp_pat[3] = (m != 0) ? DIGIT_SEG[m % 10] : (fd == 3 ? DIGIT_SEG[0] : SEG_BLANK);
            disp_pat[fd] |= SEG_POINT;
        end else if (v < 0 && v > -1000 && fd >= 1 && fd <= 2) begin
            m = -v;
            disp_pat[0] = DIGIT_SEG[m % 10];
            m /= 10;
            disp_pat[1] = (m != 0) ? DIGIT_SEG[m % 10] : DIGIT_SEG[0];
            m /= 10;
            if (m != 0) begin
                disp_pat[2] = DIGIT_SEG[m % 10];
                disp_pat[3] = SEG_MINUS;
            end else begin
                // sign sits left of the top shown digit
                disp_pat[2] = (fd == 1) ? SEG_MINUS : DIGIT_SEG[0];
                disp_pat[3] = (fd == 2) ? SEG_MINUS : SEG_BLANK;
            end
            disp_pat[fd] |= SEG_POINT;
        end
    endfunction

    // Advance the refresh divider; returns 1 when a digit is scanned out.
    function automatic bit advance_tick(output t_scan_out res);
        tick_count = tick_count + 16'd1;
        res = '0;
        if (tick_count != refresh_period_q)
            return 1'b0;
        tick_count = '0;
        if (disp_pat[3] == SEG_BLANK && disp_pat[2] == SEG_BLANK && disp_pat[1] == SEG_BLANK)
            scan_pos = '0;
        else if (disp_pat[3] == SEG_BLANK && disp_pat[2] == SEG_BLANK)
            scan_pos = 2'(scan_pos % 2);
        else if (disp_pat[3] == SEG_BLANK)
            scan_pos = 2'(scan_pos % 3);
        res.seg = disp_pat[scan_pos];
        res.sel = 4'b0001 << scan_pos;
        scan_pos = scan_pos + 2'd1;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] val,
                             input logic [FD_W-1:0] fd, input bit typed,
                             input t_seg tseg, input logic [3:0] tsel);
        int gap;
        t_scan_out res;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-VAL_W-FD_W){1'b0}}, fd, val};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        case (kind)
            KIND_TICK: begin
                if (advance_tick(res)) begin
                    if (typed) begin
                        res.seg = tseg;
                        res.sel = tsel;
                    end
                    scan_exp_q.push_back(res);
                end
            end
            KIND_INT:   show_integer(int'($signed(val)));
            KIND_FIXED: show_fixed(int'($signed(val)), int'(fd));
            default: ;
        endcase
    endtask

    // Stop offering, wait for all scans, then let in-flight updates finish.
    task automatic settle_display();
        s_axis_tvalid <= 1'b0;
        while (scan_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_refresh_period(input logic [15:0] p);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= p;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        refresh_period_q = p;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0:       v = int'($urandom_range(0, 65535));
            1:       v = int'($urandom_range(0, 9));
            2:       v = int'($urandom_range(10, 999));
            3, 4, 5: v = int'($urandom_range(0, 9999));
            6:       v = 0 - int'($urandom_range(1, 9));
            7, 8:    v = 0 - int'($urandom_range(1, 999));
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = 9999;
                    1:       v = 10000;
                    2:       v = -999;
                    3:       v = -1000;
                    4:       v = 32767;
                    default: v = -32768;
                endcase
            end
        endcase
        return v[VAL_W-1:0];
    endfunction

    task automatic random_items(input int n, input bit mid_pause);
        int pick;
        logic [KIND_W-1:0] kind;
        logic [FD_W-1:0] fd;
        for (int i = 0; i < n; i++) begin
            if (mid_pause && i == n / 2)
                settle_display();
            pick = $urandom_range(0, 99);
            if (pick < 55)      kind = KIND_TICK;
            else if (pick < 72) kind = KIND_INT;
            else if (pick < 93) kind = KIND_FIXED;
            else                kind = KIND_SPARE;
            fd = ($urandom_range(0, 3) == 0) ? FD_W'($urandom_range(0, 3))
                                             : FD_W'($urandom_range(1, 3));
            send_item(kind, pick_value(), fd, 1'b0, SEG_BLANK, 4'h0);
        end
    endtask

    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(KIND_TICK, VAL_W'($urandom_range(0, 65535)), FD_W'($urandom_range(0, 3)),
                      1'b0, SEG_BLANK, 4'h0);
    endtask

    // Receiver: per-item stall draw, long hold on request, and scan checking.
    initial begin : scan_sink
        int gap;
        t_scan_out want;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (m_axis_tvalid && m_axis_tready) begin
                    if (scan_exp_q.size() == 0) begin
                        report("unexpected scan", int'(m_axis_tdata), 0);
                    end else begin
                        want = scan_exp_q.pop_front();
                        if (m_axis_tdata[7:0] != want.seg)
                            report("segments", int'(m_axis_tdata[7:0]), int'(want.seg));
                        if (m_axis_tdata[11:8] != want.sel)
                            report("digit_select", int'(m_axis_tdata[11:8]), int'(want.sel));
                    end
                    gap = rx_idle_on ? $urandom_range(0, 5) : 0;
                end else if (!m_axis_tready && gap > 0) begin
                    gap--;
                end
                if (rx_hold_req) begin
                    gap = RX_HOLD_CYCLES;
                    rx_hold_req = 1'b0;
                end
                m_axis_tready <= (gap == 0);
            end
        end
    end

    initial begin : stimulus
        t_dir_row r;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_item(r.kind, r.val, r.fd, r.typed, r.seg, r.sel);
        end
        settle_display();

        // every tick scans; receiver holds off so the pipe backs up
        set_refresh_period(16'd1);
        tx_idle_on = 1'b0;
        rx_hold_req = 1'b1;
        random_items(80, 1'b0);
        settle_display();

        set_refresh_period(16'd3);
        tx_idle_on = 1'b1;
        random_items(100, 1'b1);
        settle_display();

        set_refresh_period(16'($urandom_range(1, 8)));
        tx_idle_on = 1'b0;
        random_items(100, 1'b0);
        settle_display();

        set_refresh_period(16'd2);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        random_items(100, 1'b0);
        settle_display();

        // max period, then zero period below the running divider: no scan in a few ticks
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b0;
        set_refresh_period(16'hFFFF);
        run_ticks(10);
        settle_display();
        set_refresh_period(16'd0);
        run_ticks(10);
        settle_display();

        if (err_count == 0)
            $display("[four_digit_seven_segment_driver] OK");
        else
            $display("[four_digit_seven_segment_driver] ERROR");
        $finish;
    end

endmodule
